// ===== hw/rtl/clipped_argb_blit_blend_macros.svh =====
// assertion macros for the clipped argb blit and blend block
// expects clk and rst_n in the scope of the module that includes it
`ifndef CLIPPED_ARGB_BLIT_BLEND_MACROS_SVH
`define CLIPPED_ARGB_BLIT_BLEND_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define CABB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CABB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cabb_pkg.sv =====
// shared constants, types and pixel arithmetic for the clipped argb blit and blend
// no dependencies
package cabb_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = 13;
    localparam int COORD_W = 14;
    localparam int IDX_W   = 24;
    localparam int PIX_W   = 32;
    localparam int ADDR_W  = 5;

    localparam logic [PIX_W-1:0] AMASK    = 32'hFF00_0000;
    localparam logic [PIX_W-1:0] RBMASK   = 32'h00FF_00FF;
    localparam logic [PIX_W-1:0] GMASK    = 32'h0000_FF00;
    localparam logic [PIX_W-1:0] AGMASK   = 32'hFF00_FF00;
    localparam logic [PIX_W-1:0] ONEALPHA = 32'h0100_0000;
    localparam logic signed [9:0] ALPHA_OPAQUE = 10'sd255;

    typedef enum logic [2:0] {
        REG_BLEND_MODE,
        REG_DEST_WIDTH,
        REG_DEST_HEIGHT,
        REG_SOURCE_WIDTH,
        REG_SOURCE_HEIGHT,
        REG_PLACE_X,
        REG_PLACE_Y,
        REG_ALPHA_BIAS
    } cfg_reg_t;

    // one accepted word with its window position
    typedef struct packed {
        logic [PIX_W-1:0] dest_pixel;
        logic [PIX_W-1:0] source_pixel;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic             last;
        logic             empty;
    } item_t;

    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    // packed red-blue / alpha-green mix, wraps modulo 2^32
    function automatic logic [PIX_W-1:0] blend_pixel(
        input logic [PIX_W-1:0] d,
        input logic [PIX_W-1:0] s,
        input logic [7:0]       bias
    );
        logic signed [9:0] sa;
        logic [PIX_W-1:0]  a;
        logic [PIX_W-1:0]  na;
        logic [PIX_W-1:0]  rb;
        logic [PIX_W-1:0]  ag;
        sa = $signed({2'b00, s[31:24]}) - $signed({2'b00, bias});
        a  = {24'd0, sa[7:0]};
        na = 32'd255 - a;
        rb = (na * (d & RBMASK) + a * (s & RBMASK)) >> 8;
        ag = na * ((d & AGMASK) >> 8) + a * (ONEALPHA | ((s & GMASK) >> 8));
        if (sa <= 10'sd0)
            return d;
        else if (sa >= ALPHA_OPAQUE)
            return s;
        else
            return (rb & RBMASK) | (ag & AGMASK);
    endfunction

endpackage

// ===== hw/rtl/clipped_argb_blit_blend.sv =====
// an accepted word goes through the input register, then the result register
// throughput: one word per cycle while out_stall is low, set by the register pair
// the window position counters advance once per accepted word in a non-empty window
// reset: control and config registers reset; the window restarts at its start
// a configuration write also restarts the window at its (new) start
module clipped_argb_blit_blend
    import cabb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     dest_pixel,
    input  logic [PIX_W-1:0]     source_pixel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     result_pixel,
    output logic [IDX_W-1:0]     dest_index,
    output logic [IDX_W-1:0]     source_index,
    output logic                 window_last,
    output logic                 window_empty
);

    `include "clipped_argb_blit_blend_macros.svh"

    logic                 blend_mode_reg;
    logic [DIM_W-1:0]     dest_width_reg;
    logic [DIM_W-1:0]     dest_height_reg;
    logic [DIM_W-1:0]     source_width_reg;
    logic [DIM_W-1:0]     source_height_reg;
    logic [COORD_W-1:0]   place_x_reg;
    logic [COORD_W-1:0]   place_y_reg;
    logic [7:0]           alpha_bias_reg;

    logic                 cfg_we;
    cfg_reg_t             cfg_sel;

    logic [DIM_W-1:0]     dw_dim;
    logic [DIM_W-1:0]     dh_dim;
    logic [DIM_W-1:0]     sw_dim;
    logic [DIM_W-1:0]     sh_dim;
    logic signed [15:0]   px;
    logic signed [15:0]   py;
    logic signed [15:0]   ex;
    logic signed [15:0]   ey;
    logic signed [15:0]   start_x;
    logic signed [15:0]   start_y;
    logic signed [15:0]   end_x;
    logic signed [15:0]   end_y;
    logic                 win_empty;

    logic [DIM_W-1:0]     col_reg;
    logic [DIM_W-1:0]     row_reg;
    logic                 restart_reg;
    logic [DIM_W-1:0]     col_next;
    logic [DIM_W-1:0]     row_next;
    logic                 restart_next;
    logic [DIM_W-1:0]     col_eff;
    logic [DIM_W-1:0]     row_eff;
    logic                 col_at_end;
    logic                 pos_last;

    item_t                item_reg;
    item_t                item_next;
    logic                 item_valid_reg;
    logic                 in_accept;
    logic                 out_load;

    logic [25:0]          dest_prod;
    logic [25:0]          source_prod;
    logic [DIM_W-1:0]     src_row;
    logic [DIM_W-1:0]     src_col;
    logic [PIX_W-1:0]     pixel_calc;

    logic                 out_valid_reg;
    logic [PIX_W-1:0]     result_pixel_reg;
    logic [IDX_W-1:0]     dest_index_reg;
    logic [IDX_W-1:0]     source_index_reg;
    logic                 window_last_reg;
    logic                 window_empty_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_sel = cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg    <= 1'b1;
            dest_width_reg    <= DIM_W'(1);
            dest_height_reg   <= DIM_W'(1);
            source_width_reg  <= '0;
            source_height_reg <= '0;
            place_x_reg       <= '0;
            place_y_reg       <= '0;
            alpha_bias_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_sel)
                REG_BLEND_MODE:    blend_mode_reg    <= pwdata[0];
                REG_DEST_WIDTH:    dest_width_reg    <= pwdata[DIM_W-1:0];
                REG_DEST_HEIGHT:   dest_height_reg   <= pwdata[DIM_W-1:0];
                REG_SOURCE_WIDTH:  source_width_reg  <= pwdata[DIM_W-1:0];
                REG_SOURCE_HEIGHT: source_height_reg <= pwdata[DIM_W-1:0];
                REG_PLACE_X:       place_x_reg       <= pwdata[COORD_W-1:0];
                REG_PLACE_Y:       place_y_reg       <= pwdata[COORD_W-1:0];
                REG_ALPHA_BIAS:    alpha_bias_reg    <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_BLEND_MODE:    prdata = {31'd0, blend_mode_reg};
            REG_DEST_WIDTH:    prdata = {19'd0, dest_width_reg};
            REG_DEST_HEIGHT:   prdata = {19'd0, dest_height_reg};
            REG_SOURCE_WIDTH:  prdata = {19'd0, source_width_reg};
            REG_SOURCE_HEIGHT: prdata = {19'd0, source_height_reg};
            REG_PLACE_X:       prdata = {18'd0, place_x_reg};
            REG_PLACE_Y:       prdata = {18'd0, place_y_reg};
            REG_ALPHA_BIAS:    prdata = {24'd0, alpha_bias_reg};
        endcase
    end

    // clipped window bounds, end exclusive
    always_comb
    begin
        dw_dim  = dim_clamp(dest_width_reg);
        dh_dim  = dim_clamp(dest_height_reg);
        sw_dim  = dim_clamp(source_width_reg);
        sh_dim  = dim_clamp(source_height_reg);
        px      = {{2{place_x_reg[COORD_W-1]}}, place_x_reg};
        py      = {{2{place_y_reg[COORD_W-1]}}, place_y_reg};
        ex      = px + $signed({3'b000, sw_dim});
        ey      = py + $signed({3'b000, sh_dim});
        start_x = px[15] ? 16'sd0 : px;
        start_y = py[15] ? 16'sd0 : py;
        end_x   = (ex > $signed({3'b000, dw_dim})) ? $signed({3'b000, dw_dim}) : ex;
        end_y   = (ey > $signed({3'b000, dh_dim})) ? $signed({3'b000, dh_dim}) : ey;
        win_empty = (end_x <= start_x) || (end_y <= start_y);
    end

    // handshake: the input register moves on whenever the result register frees up
    assign out_load  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !out_load;
    assign in_accept = in_valid && !in_stall;

    // window position, restart picks up the start of the current window
    always_comb
    begin
        col_eff    = restart_reg ? start_x[DIM_W-1:0] : col_reg;
        row_eff    = restart_reg ? start_y[DIM_W-1:0] : row_reg;
        col_at_end = $signed({3'b000, col_eff}) == (end_x - 16'sd1);
        pos_last   = col_at_end && ($signed({3'b000, row_eff}) == (end_y - 16'sd1));

        col_next     = col_reg;
        row_next     = row_reg;
        restart_next = restart_reg;
        if (cfg_we)
        begin
            restart_next = 1'b1;
        end
        else if (in_accept && !win_empty)
        begin
            restart_next = 1'b0;
            if (col_at_end)
            begin
                col_next = start_x[DIM_W-1:0];
                row_next = pos_last ? start_y[DIM_W-1:0] : row_eff + DIM_W'(1);
            end
            else
            begin
                col_next = col_eff + DIM_W'(1);
                row_next = row_eff;
            end
        end

        item_next.dest_pixel   = dest_pixel;
        item_next.source_pixel = source_pixel;
        item_next.col          = col_eff;
        item_next.row          = row_eff;
        item_next.last         = pos_last && !win_empty;
        item_next.empty        = win_empty;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            restart_reg    <= 1'b1;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            restart_reg <= restart_next;
            if (in_accept)
                item_valid_reg <= 1'b1;
            else if (out_load)
                item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            item_reg <= item_next;
    end

    // indices and pixel mix for the word in the input register
    always_comb
    begin
        src_row     = item_reg.row - place_y_reg[DIM_W-1:0];
        src_col     = item_reg.col - place_x_reg[DIM_W-1:0];
        dest_prod   = 26'(item_reg.row) * 26'(dw_dim) + 26'(item_reg.col);
        source_prod = 26'(src_row) * 26'(sw_dim) + 26'(src_col);
        if (item_reg.empty)
            pixel_calc = item_reg.dest_pixel;
        else if (blend_mode_reg)
            pixel_calc = blend_pixel(item_reg.dest_pixel, item_reg.source_pixel,
                                     alpha_bias_reg);
        else
            pixel_calc = item_reg.source_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_pixel_reg <= pixel_calc;
            dest_index_reg   <= item_reg.empty ? '0 : dest_prod[IDX_W-1:0];
            source_index_reg <= item_reg.empty ? '0 : source_prod[IDX_W-1:0];
            window_last_reg  <= item_reg.last;
            window_empty_reg <= item_reg.empty;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_pixel = result_pixel_reg;
    assign dest_index   = dest_index_reg;
    assign source_index = source_index_reg;
    assign window_last  = window_last_reg;
    assign window_empty = window_empty_reg;

    `CABB_ASSERT_SAME(a_empty_not_last, out_valid && window_empty, !window_last,
        "empty window word flagged as last")
    `CABB_ASSERT_SAME(a_empty_zero_index, out_valid && window_empty,
        dest_index == '0 && source_index == '0, "empty window word carries an index")
    `CABB_ASSERT_SAME(a_stall_needs_word, in_stall, item_valid_reg,
        "input stalled with an empty input register")
    `CABB_ASSERT_NEXT(a_load_shows, out_load, out_valid,
        "loaded word did not reach the output")
    `CABB_ASSERT_NEXT(a_cfg_restart, cfg_we, restart_reg,
        "configuration write did not restart the window")

endmodule

// ===== tb/sv/blit_result_checker.sv =====
`timescale 1ns / 100ps
// result checker for clipped_argb_blit_blend: follows register writes on the apb port,
// predicts every result word from the accepted input words and compares field by field
// depends on cabb_pkg for widths, masks and register names
module blit_result_checker
    import cabb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [PIX_W-1:0]  dest_pixel,
    input  logic [PIX_W-1:0]  source_pixel,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [PIX_W-1:0]  result_pixel,
    input  logic [IDX_W-1:0]  dest_index,
    input  logic [IDX_W-1:0]  source_index,
    input  logic              window_last,
    input  logic              window_empty,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [IDX_W-1:0] didx;
        logic [IDX_W-1:0] sidx;
        logic             last;
        logic             empty;
    } blit_word_t;

    logic               mode_blend;
    logic [DIM_W-1:0]   dst_w;
    logic [DIM_W-1:0]   dst_h;
    logic [DIM_W-1:0]   src_w;
    logic [DIM_W-1:0]   src_h;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [7:0]         bias;

    int win_x0;
    int win_y0;
    int win_x1;
    int win_y1;
    int cur_col;
    int cur_row;

    blit_word_t expected_words[$];

    function automatic int dim_of(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    // clipped window, end bounds exclusive; scan restarts at its top-left
    task automatic restart_window();
        int px;
        int py;
        int ex;
        int ey;
        px = int'($signed(pos_x));
        py = int'($signed(pos_y));
        ex = px + dim_of(src_w);
        ey = py + dim_of(src_h);
        win_x0 = (px < 0) ? 0 : px;
        win_y0 = (py < 0) ? 0 : py;
        win_x1 = (ex > dim_of(dst_w)) ? dim_of(dst_w) : ex;
        win_y1 = (ey > dim_of(dst_h)) ? dim_of(dst_h) : ey;
        cur_col = win_x0;
        cur_row = win_y0;
    endtask

    // source over destination, red-blue and alpha-green lanes, 32-bit wrap
    function automatic logic [PIX_W-1:0] mix_over(
        input logic [PIX_W-1:0] d,
        input logic [PIX_W-1:0] s,
        input logic [7:0]       b
    );
        int               sa;
        logic [PIX_W-1:0] w;
        logic [PIX_W-1:0] iw;
        logic [PIX_W-1:0] rb;
        logic [PIX_W-1:0] ag;
        sa = int'(s[31:24]) - int'(b);
        if (sa <= 0)
            return d;
        if (sa >= 255)
            return s;
        w  = sa;
        iw = 32'd255 - w;
        rb = (iw * (d & RBMASK) + w * (s & RBMASK)) >> 8;
        ag = iw * ((d & AGMASK) >> 8) + w * (ONEALPHA | ((s & GMASK) >> 8));
        return (rb & RBMASK) | (ag & AGMASK);
    endfunction

    task automatic predict_word(
        input  logic [PIX_W-1:0] d,
        input  logic [PIX_W-1:0] s,
        output blit_word_t       w
    );
        int          c;
        int          r;
        logic [31:0] didx;
        logic [31:0] sidx;
        w = '0;
        if (win_x1 <= win_x0 || win_y1 <= win_y0)
        begin
            w.pixel = d;
            w.empty = 1'b1;
        end
        else
        begin
            c = cur_col;
            r = cur_row;
            didx = r * dim_of(dst_w) + c;
            sidx = (r - int'($signed(pos_y))) * dim_of(src_w) + (c - int'($signed(pos_x)));
            w.pixel = mode_blend ? mix_over(d, s, bias) : s;
            w.didx  = didx[IDX_W-1:0];
            w.sidx  = sidx[IDX_W-1:0];
            w.last  = (c == win_x1 - 1) && (r == win_y1 - 1);
            // wrap the column at each row end, and to the window start after the final pixel
            if (c >= win_x1 - 1)
            begin
                cur_col = win_x0;
                cur_row = w.last ? win_y0 : r + 1;
            end
            else
            begin
                cur_col = c + 1;
            end
        end
    endtask

    task automatic apply_write(input logic [ADDR_W-1:0] addr, input logic [31:0] v);
        case (cfg_reg_t'(addr[ADDR_W-1:2]))
            REG_BLEND_MODE:    mode_blend = v[0];
            REG_DEST_WIDTH:    dst_w = v[DIM_W-1:0];
            REG_DEST_HEIGHT:   dst_h = v[DIM_W-1:0];
            REG_SOURCE_WIDTH:  src_w = v[DIM_W-1:0];
            REG_SOURCE_HEIGHT: src_h = v[DIM_W-1:0];
            REG_PLACE_X:       pos_x = v[COORD_W-1:0];
            REG_PLACE_Y:       pos_y = v[COORD_W-1:0];
            REG_ALPHA_BIAS:    bias = v[7:0];
            default:           ;
        endcase
        restart_window();
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 40)
            $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_word(input blit_word_t w);
        if (result_pixel !== w.pixel)
            report_mismatch("result_pixel", result_pixel, w.pixel);
        if (dest_index !== w.didx)
            report_mismatch("dest_index", 32'(dest_index), 32'(w.didx));
        if (source_index !== w.sidx)
            report_mismatch("source_index", 32'(source_index), 32'(w.sidx));
        if (window_last !== w.last)
            report_mismatch("window_last", 32'(window_last), 32'(w.last));
        if (window_empty !== w.empty)
            report_mismatch("window_empty", 32'(window_empty), 32'(w.empty));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        blit_word_t want;
        if (!rst_n)
        begin
            mode_blend = 1'b1;
            dst_w      = 1;
            dst_h      = 1;
            src_w      = 0;
            src_h      = 0;
            pos_x      = 0;
            pos_y      = 0;
            bias       = 0;
            restart_window();
            expected_words.delete();
            mismatches  = 0;
            outstanding <= 0;
        end
        else
        begin
            // older words first: the block registers every word before it reaches the output
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected result word", result_pixel, '0);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_word(want);
                end
            end
            if (psel && penable && pwrite && pready)
                apply_write(paddr, pwdata);
            if (in_valid && !in_stall)
            begin
                predict_word(dest_pixel, source_pixel, want);
                expected_words.push_back(want);
            end
            outstanding <= expected_words.size();
        end
    end

endmodule

// ===== tb/sv/tb_clipped_argb_blit_blend.sv =====
`timescale 1ns / 100ps
// top of the clipped_argb_blit_blend testbench: clock, reset, apb writes, pixel stimulus
// and the verdict; checking is done by blit_result_checker
// depends on cabb_pkg, clipped_argb_blit_blend and blit_result_checker
module tb_clipped_argb_blit_blend;
    import cabb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1700;
    localparam int QUIET_FROM   = 1450;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [PIX_W-1:0]  dest_pixel = '0;
    logic [PIX_W-1:0]  source_pixel = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [PIX_W-1:0]  result_pixel;
    logic [IDX_W-1:0]  dest_index;
    logic [IDX_W-1:0]  source_index;
    logic              window_last;
    logic              window_empty;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int items_sent = 0;
    bit idle_on = 1'b1;
    bit quiet = 1'b0;

    always #6 clk = ~clk;

    clipped_argb_blit_blend dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dest_pixel   (dest_pixel),
        .source_pixel (source_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_pixel (result_pixel),
        .dest_index   (dest_index),
        .source_index (source_index),
        .window_last  (window_last),
        .window_empty (window_empty)
    );

    blit_result_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dest_pixel   (dest_pixel),
        .source_pixel (source_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_pixel (result_pixel),
        .dest_index   (dest_index),
        .source_index (source_index),
        .window_last  (window_last),
        .window_empty (window_empty),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver stalls at random in bursts of random length
    initial
    begin
        forever
        begin
            @(posedge clk);
            out_stall <= idle_on && !quiet && ($urandom_range(2) == 0);
            repeat ($urandom_range(0, 7)) @(posedge clk);
        end
    end

    // every task below starts and ends just after a rising edge
    task automatic send_word(input logic [PIX_W-1:0] d, input logic [PIX_W-1:0] s);
        if (idle_on && !quiet && $urandom_range(5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        dest_pixel   <= d;
        source_pixel <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // psel stays high across back-to-back writes; end_apb drops it
    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({r, 2'b00});
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic end_apb();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait until every word has come out, then give the pipeline time to empty
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int          kind;
        int          n;
        int          dw;
        int          dh;
        int          sw;
        int          sh;
        int          px;
        int          py;
        int          cw;
        int          ch;
        logic [31:0] vals[8];
        logic [7:0]  bias_now;
        logic [7:0]  alpha;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset registers give an empty window
        send_word(32'h0000_0000, 32'h0000_0000);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // copy mode, window clipped at the far corner of the largest bitmap
        drain_block();
        write_reg(REG_BLEND_MODE, 32'd0);
        write_reg(REG_DEST_WIDTH, 32'd4096);
        write_reg(REG_DEST_HEIGHT, 32'd4096);
        write_reg(REG_SOURCE_WIDTH, 32'd3);
        write_reg(REG_SOURCE_HEIGHT, 32'd2);
        write_reg(REG_PLACE_X, 32'd4094);
        write_reg(REG_PLACE_Y, 32'd4094);
        end_apb();
        send_word(32'h0000_0000, 32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFF, 32'h0000_0000);
        send_word(32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_word($urandom, $urandom);
        send_word($urandom, $urandom);

        // blend mode, oversized source at negative position covers the whole bitmap
        drain_block();
        write_reg(REG_BLEND_MODE, 32'd1);
        write_reg(REG_DEST_WIDTH, 32'd3);
        write_reg(REG_DEST_HEIGHT, 32'd2);
        write_reg(REG_SOURCE_WIDTH, 32'd8191);
        write_reg(REG_SOURCE_HEIGHT, 32'd8191);
        write_reg(REG_PLACE_X, (-5) & 32'h3FFF);
        write_reg(REG_PLACE_Y, (-7) & 32'h3FFF);
        write_reg(REG_ALPHA_BIAS, 32'd0);
        end_apb();
        send_word(32'h1234_5678, 32'h00AB_CDEF);
        send_word(32'h1234_5678, 32'hFFAB_CDEF);
        send_word(32'hFFFF_FFFF, 32'h80FF_FFFF);
        send_word(32'h00FF_00FF, 32'h01FF_00FF);
        send_word(32'hFF00_FF00, 32'hFE00_FF00);
        send_word(32'h0000_0000, 32'hFFFF_FFFF);

        // alpha bias: cancels opaque alpha, goes below zero, leaves just under opaque
        drain_block();
        write_reg(REG_ALPHA_BIAS, 32'd255);
        end_apb();
        send_word(32'h8899_AABB, 32'hFF12_3456);
        drain_block();
        write_reg(REG_ALPHA_BIAS, 32'd100);
        end_apb();
        send_word(32'h8899_AABB, 32'h3212_3456);
        drain_block();
        write_reg(REG_ALPHA_BIAS, 32'd1);
        end_apb();
        send_word(32'h8899_AABB, 32'hFF12_3456);

        // placements that clip everything away, and a zero destination width
        drain_block();
        write_reg(REG_SOURCE_WIDTH, 32'd4096);
        write_reg(REG_PLACE_X, (-4096) & 32'h3FFF);
        end_apb();
        send_word($urandom, $urandom);
        drain_block();
        write_reg(REG_PLACE_X, 32'd4096);
        end_apb();
        send_word($urandom, $urandom);
        drain_block();
        write_reg(REG_PLACE_X, 32'd0);
        write_reg(REG_DEST_WIDTH, 32'd0);
        end_apb();
        send_word($urandom, $urandom);

        items_sent = 0;
        bias_now = 8'd1;
        while (items_sent < RANDOM_WORDS)
        begin
            drain_block();
            quiet   = (items_sent >= QUIET_FROM);
            idle_on = ($urandom_range(3) != 0);
            kind    = $urandom_range(9);
            case ($urandom_range(3))
                0:       bias_now = 8'd0;
                1:       bias_now = 8'd255;
                default: bias_now = 8'($urandom);
            endcase
            if (kind <= 6)
            begin
                dw = $urandom_range(1, 8);
                dh = $urandom_range(1, 8);
                sw = $urandom_range(0, 10);
                sh = $urandom_range(0, 10);
                px = int'($urandom_range(20)) - 10;
                py = int'($urandom_range(20)) - 10;
            end
            else if (kind == 7)
            begin
                // small window at the bottom-right of a large bitmap
                case ($urandom_range(2))
                    0:       dw = 4096;
                    1:       dw = 8191;
                    default: dw = $urandom_range(1, 8191);
                endcase
                case ($urandom_range(2))
                    0:       dh = 4096;
                    1:       dh = 8191;
                    default: dh = $urandom_range(1, 8191);
                endcase
                cw = (dw > MAX_DIM) ? MAX_DIM : dw;
                ch = (dh > MAX_DIM) ? MAX_DIM : dh;
                sw = $urandom_range(1, 6);
                sh = $urandom_range(1, 6);
                px = cw - int'($urandom_range(1, 6));
                py = ch - int'($urandom_range(1, 6));
            end
            else if (kind == 8)
            begin
                // any bit pattern, including zero and oversized dimensions
                dw = $urandom_range(0, 8191);
                dh = $urandom_range(0, 8191);
                sw = $urandom_range(0, 8191);
                sh = $urandom_range(0, 8191);
                px = $urandom_range(0, 16383);
                py = $urandom_range(0, 16383);
            end
            else
            begin
                // large source mostly off the top-left: high source indices
                dw = $urandom_range(1, 8);
                dh = $urandom_range(1, 8);
                sw = 4096;
                sh = 4096;
                px = int'($urandom_range(1, 8)) - 4096;
                py = int'($urandom_range(1, 8)) - 4096;
            end
            vals[REG_BLEND_MODE]    = ($urandom_range(3) != 0) ? 32'd1 : 32'd0;
            vals[REG_DEST_WIDTH]    = dw;
            vals[REG_DEST_HEIGHT]   = dh;
            vals[REG_SOURCE_WIDTH]  = sw;
            vals[REG_SOURCE_HEIGHT] = sh;
            vals[REG_PLACE_X]       = px & 32'h3FFF;
            vals[REG_PLACE_Y]       = py & 32'h3FFF;
            vals[REG_ALPHA_BIAS]    = {24'd0, bias_now};
            for (int i = 0; i < 8; i++)
                if ($urandom_range(4) != 0)
                    write_reg(cfg_reg_t'(i), vals[i]);
            end_apb();

            n = (kind == 8) ? $urandom_range(5, 30) : $urandom_range(10, 90);
            for (int k = 0; k < n; k++)
            begin
                // alpha near the bias boundaries as often as at random
                case ($urandom_range(7))
                    0:       alpha = bias_now;
                    1:       alpha = bias_now + 8'd1;
                    2:       alpha = bias_now - 8'd1;
                    3:       alpha = 8'hFF;
                    4:       alpha = 8'h00;
                    default: alpha = 8'($urandom);
                endcase
                send_word($urandom, {alpha, 24'($urandom)});
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
